// ===== design/pq_pkg.sv =====
// Shared constants and types for the two-lane product-quantized dot-product core.
package pq_pkg;

  localparam int CODE_COUNT_DEF   = 256;
  localparam int MAX_ELEMENTS_DEF = 4096;

  localparam int CODE_W      = 8;
  localparam int VAL_W       = 8;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int SUM_W       = 32;
  localparam int COUNT_OUT_W = 13;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DEPTH   = 2;
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_ACC   = 1'b1;

  // Accumulate request after codebook lookup, handed from front to back
  typedef struct packed {
    logic signed [VAL_W-1:0] even_cb;
    logic signed [VAL_W-1:0] odd_cb;
    logic signed [VAL_W-1:0] x;
    logic                    last;
  } acc_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] even_sum;
    logic signed [SUM_W-1:0] odd_sum;
    logic [COUNT_OUT_W-1:0]  element_count;
  } result_t;

endpackage

// ===== design/pq_ram.sv =====
// Generic single-port RAM with registered read data.
module pq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/pq_fifo.sv =====
// Generic small first-in first-out queue built from flip-flops.
module pq_fifo #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [W-1:0]             push_data,
  input  logic                     pop,
  output logic [W-1:0]             head,
  output logic                     empty,
  output logic [$clog2(D+1)-1:0]   count
);

  localparam int AW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  logic [W-1:0]  store_r [D];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(D - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(D - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = store_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

// ===== design/pq_front.sv =====
// Front end: takes requests, writes the codebook, looks up codes and queues accumulates.
module pq_front import pq_pkg::*; #(
  parameter int CODE_COUNT = CODE_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic                    in_action,
  input  logic [CODE_W-1:0]       in_code_index,
  input  logic signed [VAL_W-1:0] in_even_entry,
  input  logic signed [VAL_W-1:0] in_odd_entry,
  input  logic signed [VAL_W-1:0] in_x_value,
  input  logic                    in_last,
  input  logic [QUEUE_CNT_W-1:0]  q_count,
  output logic                    q_push,
  output acc_item_t               q_item
);

  localparam int AW = $clog2(CODE_COUNT);

  logic                    accept;
  logic                    hit;
  logic                    book_we;
  logic [AW-1:0]           book_addr;
  logic [VAL_W-1:0]        even_rd, odd_rd;
  logic                    s1_v_r;
  logic                    s1_hit_r;
  logic signed [VAL_W-1:0] s1_x_r;
  logic                    s1_last_r;
  logic [QUEUE_CNT_W:0]    pending;

  // Reserve a queue slot for the lookup still in flight
  assign pending = {1'b0, q_count} + (QUEUE_CNT_W + 1)'(s1_v_r);
  assign full    = (pending >= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH));
  assign accept  = push && !full;

  assign hit       = ({1'b0, in_code_index} < (CODE_W + 1)'(CODE_COUNT));
  assign book_addr = in_code_index[AW-1:0];
  assign book_we   = accept && (in_action == ACT_WRITE) && hit;

  pq_ram #(.WIDTH(VAL_W), .DEPTH(CODE_COUNT)) u_even_book (
    .clk   (clk),
    .we    (book_we),
    .addr  (book_addr),
    .wdata (in_even_entry),
    .rdata (even_rd)
  );

  pq_ram #(.WIDTH(VAL_W), .DEPTH(CODE_COUNT)) u_odd_book (
    .clk   (clk),
    .we    (book_we),
    .addr  (book_addr),
    .wdata (in_odd_entry),
    .rdata (odd_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept && (in_action == ACT_ACC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit_r  <= hit;
      s1_x_r    <= in_x_value;
      s1_last_r <= in_last;
    end
  end

  // Codes beyond the codebook read as zero
  always_comb begin
    q_push         = s1_v_r;
    q_item.even_cb = s1_hit_r ? $signed(even_rd) : '0;
    q_item.odd_cb  = s1_hit_r ? $signed(odd_rd) : '0;
    q_item.x       = s1_x_r;
    q_item.last    = s1_last_r;
  end

endmodule

// ===== design/pq_back.sv =====
// Back end: multiplies looked-up codebook values by the input and accumulates both lanes.
module pq_back import pq_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acc_item_t            q_head,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic [OUT_CNT_W-1:0] res_count,
  output logic                 res_push,
  output result_t              res
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic                     a_v_r;
  logic signed [PROD_W-1:0] a_prod_e_r, a_prod_o_r;
  logic                     a_last_r;
  logic                     a_adv;
  logic                     take;
  logic signed [SUM_W-1:0]  acc_e_r, acc_e_nxt, sum_e;
  logic signed [SUM_W-1:0]  acc_o_r, acc_o_nxt, sum_o;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt, cnt_sum;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  // Hold a final element while the result queue has no room
  assign a_adv = a_v_r && (!a_last_r || (res_count != OUT_CNT_W'(OUT_DEPTH)));
  assign q_pop = !q_empty && (!a_v_r || a_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (q_pop) begin
      a_v_r <= 1'b1;
    end else if (a_adv) begin
      a_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_prod_e_r <= q_head.even_cb * q_head.x;
      a_prod_o_r <= q_head.odd_cb * q_head.x;
      a_last_r   <= q_head.last;
    end
  end

  // Drop elements past the vector length limit
  assign take    = (cnt_r < CNT_W'(MAX_ELEMENTS));
  assign sum_e   = take ? acc_e_r + {{(SUM_W - PROD_W){a_prod_e_r[PROD_W-1]}}, a_prod_e_r}
                        : acc_e_r;
  assign sum_o   = take ? acc_o_r + {{(SUM_W - PROD_W){a_prod_o_r[PROD_W-1]}}, a_prod_o_r}
                        : acc_o_r;
  assign cnt_sum = cnt_r + CNT_W'(take);
  assign cnt_ext = {{COUNT_OUT_W{1'b0}}, cnt_sum};

  always_comb begin
    acc_e_nxt = acc_e_r;
    acc_o_nxt = acc_o_r;
    cnt_nxt   = cnt_r;
    if (a_adv) begin
      if (a_last_r) begin
        acc_e_nxt = '0;
        acc_o_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        acc_e_nxt = sum_e;
        acc_o_nxt = sum_o;
        cnt_nxt   = cnt_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_e_r <= '0;
      acc_o_r <= '0;
      cnt_r   <= '0;
    end else begin
      acc_e_r <= acc_e_nxt;
      acc_o_r <= acc_o_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign res_push          = a_adv && a_last_r;
  assign res.even_sum      = sum_e;
  assign res.odd_sum       = sum_o;
  assign res.element_count = cnt_ext[COUNT_OUT_W-1:0];

endmodule

// ===== design/pq_lut_dot_product_two_lane.sv =====
// Top level of the two-lane product-quantized dot-product core.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------------
//   input    | push / full         | in_action, in_code_index, in_even_entry,
//            |                     | in_odd_entry, in_x_value, in_last
//   result   | empty / pop         | out_even_sum, out_odd_sum, out_element_count
//
// One request per cycle is taken while full is low, codebook writes and accumulates alike.
// A result shows on the result ports once the request that ends the vector has passed
// through; the path is codebook RAM read, lookup queue, multiply, accumulate, result queue.
// Reset clears accumulators, count and queues; codebook contents are not cleared.
// A stalled result fills the result queue, then the lookup queue, then raises full.
module pq_lut_dot_product_two_lane import pq_pkg::*; #(
  parameter int CODE_COUNT   = CODE_COUNT_DEF,
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic                    in_action,
  input  logic [CODE_W-1:0]       in_code_index,
  input  logic signed [VAL_W-1:0] in_even_entry,
  input  logic signed [VAL_W-1:0] in_odd_entry,
  input  logic signed [VAL_W-1:0] in_x_value,
  input  logic                    in_last,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [SUM_W-1:0] out_even_sum,
  output logic signed [SUM_W-1:0] out_odd_sum,
  output logic [COUNT_OUT_W-1:0]  out_element_count
);

  acc_item_t            q_in_item, q_head;
  logic                 q_push, q_pop, q_empty;
  logic [QUEUE_CNT_W-1:0] q_count;
  result_t              res_in, res_head;
  logic                 res_push, res_pop;
  logic [OUT_CNT_W-1:0] res_count;

  pq_front #(.CODE_COUNT(CODE_COUNT)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_action     (in_action),
    .in_code_index (in_code_index),
    .in_even_entry (in_even_entry),
    .in_odd_entry  (in_odd_entry),
    .in_x_value    (in_x_value),
    .in_last       (in_last),
    .q_count       (q_count),
    .q_push        (q_push),
    .q_item        (q_in_item)
  );

  pq_fifo #(.W($bits(acc_item_t)), .D(QUEUE_DEPTH)) u_lookup_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in_item),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  pq_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  assign res_pop = pop && !empty;

  pq_fifo #(.W($bits(result_t)), .D(OUT_DEPTH)) u_result_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .pop       (res_pop),
    .head      (res_head),
    .empty     (empty),
    .count     (res_count)
  );

  assign out_even_sum      = res_head.even_sum;
  assign out_odd_sum       = res_head.odd_sum;
  assign out_element_count = res_head.element_count;

endmodule

// ===== design/pq_checker.sv =====
// Port-level checker for the dot-product core, bound to the top level.
module pq_checker import pq_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    push,
  input logic                    full,
  input logic                    in_action,
  input logic                    in_last,
  input logic                    empty,
  input logic                    pop,
  input logic signed [SUM_W-1:0] out_even_sum,
  input logic signed [SUM_W-1:0] out_odd_sum,
  input logic [COUNT_OUT_W-1:0]  out_element_count
);

  logic [15:0] owed_r, owed_nxt;
  logic        end_req, res_taken;

  assign end_req   = push && !full && (in_action == ACT_ACC) && in_last;
  assign res_taken = pop && !empty;

  always_comb begin
    owed_nxt = owed_r;
    if (end_req && !res_taken) begin
      owed_nxt = owed_r + 1'b1;
    end else if (res_taken && !end_req) begin
      owed_nxt = owed_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= '0;
    end else begin
      owed_r <= owed_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (owed_r != '0))
    else $error("result shown without a pending end-of-vector request");

  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without a request taken");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_even_sum) && $stable(out_odd_sum)
      && $stable(out_element_count))
    else $error("stalled result changed");

endmodule

bind pq_lut_dot_product_two_lane pq_checker u_pq_checker (.*);
